// File: rtl/core/wseo_pkg.sv
// ----------------------------------------------------------------------------
// wseo_pkg
// Types and constants for the extension offer parser: beat payloads, offer
// prefix, parameter names and header flag positions.
// ----------------------------------------------------------------------------
package wseo_pkg;

    // default cap on header value length in bytes
    localparam int WSEO_MAX_VALUE_BYTES = 1023;

    // offer prefix
    localparam int                    PREFIX_LEN = 18;
    localparam logic [8*PREFIX_LEN-1:0] PREFIX_STR = "permessage-deflate";

    // parameter names, right-justified in a common width
    localparam int NAME_CNT = 4;
    localparam int NAME_MAX = 26;
    localparam logic [8*NAME_MAX-1:0] NAME_STR [NAME_CNT] = '{
        {"client_no", "_context_takeover"},
        {"server_no", "_context_takeover"},
        {"server_max", "_window_bits"},
        {"client_max", "_window_bits"}
    };
    localparam logic [4:0] NAME_LEN [NAME_CNT] = '{5'd26, 5'd26, 5'd22, 5'd22};

    // name indexes
    localparam logic [2:0] NM_CNT   = 3'd0;
    localparam logic [2:0] NM_SNT   = 3'd1;
    localparam logic [2:0] NM_SBITS = 3'd2;
    localparam logic [2:0] NM_CBITS = 3'd3;
    localparam logic [2:0] NM_NONE  = 3'd4;

    // header flag bit positions
    localparam int FL_DEFLATE = 0;
    localparam int FL_CNT     = 1;
    localparam int FL_SNT     = 2;
    localparam int FL_SBITS   = 3;
    localparam int FL_CBITS   = 4;

    // window bits range that sets a flag
    localparam logic [7:0] WBITS_MIN = 8'd8;
    localparam logic [7:0] WBITS_MAX = 8'd15;
    localparam logic [7:0] SAT_MAX   = 8'd255;

    // characters
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       last_byte;
    } t_wseo_in;

    typedef struct packed {
        logic       deflate_offered;
        logic       client_no_takeover;
        logic       server_no_takeover;
        logic       server_bits_flag;
        logic       client_bits_flag;
        logic [7:0] server_bits_value;
        logic [7:0] client_bits_value;
    } t_wseo_out;

endpackage

// File: rtl/core/websocket_extension_offer_parser.sv
// ----------------------------------------------------------------------------
// websocket_extension_offer_parser
// Scans one Sec-WebSocket-Extensions header value for a permessage-deflate
// offer and its parameters.
// ----------------------------------------------------------------------------
// usage
//   input channel: one header byte per beat, last_byte marks the final byte
//   of a header value; a zero byte ends the scan, and later bytes, like any
//   byte past MAX_VALUE_BYTES, are ignored up to the last byte
//   output channel: exactly one result beat per header, built from the last
//   input beat; no beat for other bytes
//   throughput: one input beat per cycle while input is not held off (see stall); every byte goes through
//   one pass of matching logic from the scan registers back into them
//   latency: the result is valid in the cycle after the last byte is taken
//   stall: the result sits in the output register; input beats are held off
//   only while that register is full and the receiver is not taking it
//   reset: scan state clears to start of offer, flags clear, both stored
//   window values clear to zero, output register empties
//   stored window values persist across headers; flags clear after each one
// ----------------------------------------------------------------------------
module websocket_extension_offer_parser #(
    parameter int MAX_VALUE_BYTES = wseo_pkg::WSEO_MAX_VALUE_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  wseo_pkg::t_wseo_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output wseo_pkg::t_wseo_out o_out_data
);
    import wseo_pkg::*;

    localparam int CNT_W = $clog2(MAX_VALUE_BYTES + 1);

    typedef enum logic [3:0] {
        PH_OFFER     = 4'd0,
        PH_PREFIX    = 4'd1,
        PH_SKIPOFFER = 4'd2,
        PH_AFTER     = 4'd3,
        PH_PSTART    = 4'd4,
        PH_PNAME     = 4'd5,
        PH_PTRAIL    = 4'd6,
        PH_PVAL      = 4'd7,
        PH_PVALEND   = 4'd8,
        PH_PSKIP     = 4'd9,
        PH_DONE      = 4'd10
    } t_phase;

    typedef struct packed {
        t_phase     phase;
        logic [4:0] pos;    // match position in prefix or name
        logic [3:0] mask;   // live parameter names
        logic [4:0] flags;
        logic [7:0] acc;    // digit accumulator
        logic [7:0] sst;    // server window bits store
        logic [7:0] cst;    // client window bits store
    } t_scan;

    t_scan            r_scan, n_scan;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic             r_out_valid;
    t_wseo_out        r_out,  n_out;
    logic             w_in_acc;
    logic             w_take;

    // ------------------------------------------------------------------
    // character helpers
    // ------------------------------------------------------------------
    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [7:0] prefix_char(input logic [4:0] p);
        int idx;
        idx = (int'(p) < PREFIX_LEN) ? PREFIX_LEN - 1 - int'(p) : 0;
        return PREFIX_STR[8*idx +: 8];
    endfunction

    function automatic logic [7:0] name_char(input logic [1:0] k, input logic [4:0] p);
        int idx;
        idx = (p < NAME_LEN[k]) ? int'(NAME_LEN[k]) - 1 - int'(p) : 0;
        return NAME_STR[k][8*idx +: 8];
    endfunction

    // lowest live name whose full length has been matched
    function automatic logic [2:0] full_name(input t_scan s);
        logic [2:0] k;
        k = NM_NONE;
        for (int i = NAME_CNT - 1; i >= 0; i--) begin
            if (s.mask[i] && NAME_LEN[i] == s.pos) begin
                k = 3'(i);
            end
        end
        return k;
    endfunction

    // ------------------------------------------------------------------
    // parameter close: record a bare name or a window value
    // ------------------------------------------------------------------
    function automatic t_scan close_param(input t_scan s);
        t_scan      r;
        logic [2:0] k;
        logic       ok;
        r  = s;
        k  = full_name(s);
        ok = (s.acc >= WBITS_MIN) && (s.acc <= WBITS_MAX);
        if (s.phase == PH_PNAME || s.phase == PH_PTRAIL) begin
            if (k == NM_CNT) begin
                r.flags[FL_CNT] = 1'b1;
            end else if (k == NM_SNT) begin
                r.flags[FL_SNT] = 1'b1;
            end else if (k == NM_SBITS) begin
                r.flags[FL_SBITS] = 1'b1;
                r.sst = '0;
            end else if (k == NM_CBITS) begin
                r.flags[FL_CBITS] = 1'b1;
                r.cst = '0;
            end
        end else if (s.phase == PH_PVAL || s.phase == PH_PVALEND) begin
            if (k == NM_SBITS) begin
                r.sst = s.acc;
                if (ok) begin
                    r.flags[FL_SBITS] = 1'b1;
                end
            end else if (k == NM_CBITS) begin
                r.cst = s.acc;
                if (ok) begin
                    r.flags[FL_CBITS] = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // narrow the live names by one character
    function automatic t_scan start_name(input t_scan s, input logic [7:0] c);
        t_scan      r;
        logic [3:0] keep;
        r = s;
        for (int k = 0; k < NAME_CNT; k++) begin
            keep[k] = s.mask[k] && (s.pos < NAME_LEN[k]) && (name_char(2'(k), s.pos) == c);
        end
        r.mask  = keep;
        r.pos   = s.pos + 5'd1;
        r.phase = (keep != '0) ? PH_PNAME : PH_PSKIP;
        return r;
    endfunction

    function automatic t_scan in_param(input t_scan s, input logic [7:0] c);
        t_scan       r;
        logic [2:0]  k;
        logic [11:0] v;
        r = s;
        k = full_name(s);
        v = 12'(s.acc) * 12'd10 + 12'(c - CH_ZERO);
        if (c == CH_SEMI || c == CH_COMMA) begin
            r       = close_param(s);
            r.phase = (c == CH_SEMI) ? PH_PSTART : PH_DONE;
        end else begin
            unique case (s.phase)
                PH_PSTART: begin
                    if (!is_ws(c)) begin
                        r.mask = '1;
                        r.pos  = '0;
                        r      = start_name(r, c);
                    end
                end
                PH_PNAME: begin
                    if (k != NM_NONE && is_ws(c)) begin
                        r.phase = PH_PTRAIL;
                    end else if ((k == NM_SBITS || k == NM_CBITS) && c == CH_EQ) begin
                        r.acc   = '0;
                        r.phase = PH_PVAL;
                    end else begin
                        r = start_name(s, c);
                    end
                end
                PH_PTRAIL: begin
                    if (!is_ws(c)) begin
                        r.phase = PH_PSKIP;
                    end
                end
                PH_PVAL: begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        r.acc = (v > 12'(SAT_MAX)) ? SAT_MAX : v[7:0];
                    end else begin
                        r.phase = PH_PVALEND;
                    end
                end
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_scan take_byte(input t_scan s, input logic [7:0] c);
        t_scan r;
        r = s;
        unique case (s.phase)
            PH_OFFER: begin
                if (c != CH_COMMA && !is_ws(c)) begin
                    if (c == prefix_char(5'd0)) begin
                        r.pos   = 5'd1;
                        r.phase = PH_PREFIX;
                    end else begin
                        r.phase = PH_SKIPOFFER;
                    end
                end
            end
            PH_PREFIX: begin
                if (int'(s.pos) < PREFIX_LEN && c == prefix_char(s.pos)) begin
                    r.pos = s.pos + 5'd1;
                    if (int'(r.pos) == PREFIX_LEN) begin
                        r.flags[FL_DEFLATE] = 1'b1;
                        r.phase             = PH_AFTER;
                    end
                end else begin
                    r.phase = (c == CH_COMMA) ? PH_OFFER : PH_SKIPOFFER;
                end
            end
            PH_SKIPOFFER: begin
                if (c == CH_COMMA) begin
                    r.phase = PH_OFFER;
                end
            end
            PH_AFTER: begin
                r.phase = (c == CH_SEMI) ? PH_PSTART : PH_DONE;
            end
            PH_DONE: begin
            end
            default: begin
                r = in_param(s, c);
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // handshake: hold off input only while a result is stuck
    // ------------------------------------------------------------------
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // byte is scanned unless the string already ended or is overlong
    assign w_take = (r_scan.phase != PH_DONE) && (r_cnt < CNT_W'(MAX_VALUE_BYTES));

    // ------------------------------------------------------------------
    // single pass per beat
    // ------------------------------------------------------------------
    always_comb begin
        t_scan s;
        s     = r_scan;
        n_cnt = r_cnt;
        n_out = r_out;
        if (w_in_acc) begin
            if (w_take) begin
                n_cnt = r_cnt + CNT_W'(1);
                if (i_in_data.value_byte == CH_NUL) begin
                    s       = close_param(s);
                    s.phase = PH_DONE;
                end else begin
                    s = take_byte(s, i_in_data.value_byte);
                end
            end
            if (i_in_data.last_byte) begin
                // close any open parameter, then report
                if (s.phase != PH_DONE) begin
                    s       = close_param(s);
                    s.phase = PH_DONE;
                end
                n_out.deflate_offered    = s.flags[FL_DEFLATE];
                n_out.client_no_takeover = s.flags[FL_CNT];
                n_out.server_no_takeover = s.flags[FL_SNT];
                n_out.server_bits_flag   = s.flags[FL_SBITS];
                n_out.client_bits_flag   = s.flags[FL_CBITS];
                n_out.server_bits_value  = s.sst;
                n_out.client_bits_value  = s.cst;
                // header state back to start; stores persist
                s.phase = PH_OFFER;
                s.pos   = '0;
                s.mask  = '1;
                s.flags = '0;
                s.acc   = '0;
                n_cnt   = '0;
            end
        end
        n_scan = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan.phase <= PH_OFFER;
            r_scan.pos   <= '0;
            r_scan.mask  <= '1;
            r_scan.flags <= '0;
            r_scan.acc   <= '0;
            r_scan.sst   <= '0;
            r_scan.cst   <= '0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_scan <= n_scan;
            r_cnt  <= n_cnt;
            if (w_in_acc && i_in_data.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_out <= n_out;
    end

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    a_ready_only_blocked_by_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid
    ) else $error("input held off with no pending result");

    a_last_gives_result: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in_data.last_byte) |=> (o_out_valid && r_scan.flags == '0 && r_cnt == '0)
    ) else $error("last byte did not report and clear header state");

    a_result_from_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_in_acc && i_in_data.last_byte)
    ) else $error("result appeared without a last byte");

    a_params_need_deflate: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_scan.flags[FL_CBITS:FL_CNT] != '0) |-> r_scan.flags[FL_DEFLATE]
    ) else $error("parameter flag set without a deflate offer");

endmodule

// File: tb/tb_websocket_extension_offer_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_extension_offer_parser
// Feeds extension header values one byte per beat, with random gaps on the
// input side and random stalls on the result side. Each result beat is checked
// field by field against a typed-in value or an in-bench offer scanner of the
// same phases, name matching, digit accumulation and stored window values. A
// directed table runs first, then randomly built headers, mostly well formed.
// ----------------------------------------------------------------------------
module tb_websocket_extension_offer_parser;

    import wseo_pkg::*;

    // scanner phases of the in-bench predictor
    typedef enum logic [3:0] {
        SC_OFFER,
        SC_PREFIX,
        SC_SKIP_OFFER,
        SC_AFTER,
        SC_PARAM_START,
        SC_PARAM_NAME,
        SC_PARAM_TRAIL,
        SC_PARAM_VAL,
        SC_PARAM_VAL_END,
        SC_PARAM_SKIP,
        SC_DONE
    } t_scan;

    // one row of the directed table: text, leading space fill, optional zero
    // byte position, and a typed-in result where it is obvious
    typedef struct {
        string     text;
        int        fill;
        int        nul_at;
        bit        typed;
        t_wseo_out want;
    } t_row;

    // per-header expectation source: typed value or predictor
    typedef struct {
        bit        typed;
        t_wseo_out want;
    } t_hdr_check;

    localparam int DIRECTED_ROWS  = 20;
    localparam int RANDOM_HEADERS = 8;
    localparam int TOTAL_BEATS    = 1000;
    localparam int MAX_WAIT       = 12;

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_wseo_in  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_wseo_out out_data;

    websocket_extension_offer_parser dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // directed headers; rows with typed = 0 are checked against the predictor
    // parameter names are written as tokens {cnt}, {snt}, {sbits}, {cbits}
    t_row directed_rows [DIRECTED_ROWS] = '{
        '{"", 0, -1, 1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0}},
        '{"permessage-deflate", 0, -1, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd0, 8'd0}},
        '{"x-webkit-deflate-frame, permessage-deflate; {cnt} ;\t{snt}",
          0, -1, 1'b1, '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'd0, 8'd0}},
        '{"permessage-deflate;{sbits}=10;{cbits}", 0, -1, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 8'd10, 8'd0}},
        '{"permessage-deflate; {sbits}=999", 0, -1, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255, 8'd0}},
        '{"permessage-deflate;{cbits}=7", 0, -1, 1'b1,
          '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255, 8'd7}},
        '{"Permessage-deflate;{cnt}", 0, -1, 1'b1,
          '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'd255, 8'd7}},
        '{"permessage-deflate;{cbits}=15x;{sbits}=8", 0, -1, 1'b0, '0},
        '{"permessage-deflatex;{cnt}", 0, -1, 1'b0, '0},
        '{"permessage-deflat, permessage-deflate;{snt}", 0, -1, 1'b0, '0},
        '{"permessage-deflate;{cbits}=;{sbits}= 9", 0, -1, 1'b0, '0},
        '{"permessage-deflate;{cnt};{snt}", 0, 45, 1'b0, '0},
        '{"permessage-deflate;{sbits} \t;{cbits} x;{cnt}x", 0, -1, 1'b0, '0},
        '{"permessage-deflate;{sbits}=12, permessage-deflate;{cnt}", 0, -1, 1'b0, '0},
        '{"foo;bar=1,,\t , permessage-deflate;{cbits}\t=9;{sbits}=0255;unknown",
          0, -1, 1'b0, '0},
        '{"permessage-deflate;{snt}", 2, -1, 1'b0, '0},
        '{"permessage-deflate", 3, -1, 1'b0, '0},
        '{"permessage-deflate;{cbits}=256\377;{sbits}=08", 0, -1, 1'b0, '0},
        '{",,  permessage-deflate,{cnt}", 0, -1, 1'b0, '0},
        '{"{cnt};permessage-deflate", 0, -1, 1'b0, '0}
    };

    // offers that precede or follow the deflate offer in random headers
    string other_offers [7] = '{
        "x-webkit-deflate-frame",
        "foo;bar=1",
        "permessage-deflat",
        "permessage-deflatE",
        "p",
        "mux; max-channels=4",
        "permessage-deflateX;{cnt}"
    };

    // predictor state
    t_scan      scan_st   = SC_OFFER;
    int         name_pos  = 0;
    logic [3:0] name_live = '1;
    int         hdr_bytes = 0;
    logic [4:0] hdr_flags = '0;
    logic [7:0] win_acc   = '0;
    logic [7:0] srv_win   = '0;
    logic [7:0] cli_win   = '0;

    t_wseo_out  expected_offers [$];
    t_hdr_check header_checks [$];
    logic [7:0] hdr_q [$];

    bit quiet = 1'b0;
    int headers_sent    = 0;
    int beats_sent      = 0;
    int bytes_parsed    = 0;
    int deflate_seen    = 0;
    int results_checked = 0;
    int mismatches      = 0;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard limit on the run
    initial begin : watchdog
        #5000000;
        $display("tb_websocket_extension_offer_parser failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // names sit right-justified in the package constants
    function automatic logic [7:0] name_char(input int k, input int p);
        return NAME_STR[k][8*(int'(NAME_LEN[k]) - 1 - p) +: 8];
    endfunction

    function automatic logic [7:0] prefix_char(input int p);
        return PREFIX_STR[8*(PREFIX_LEN - 1 - p) +: 8];
    endfunction

    // live parameter name matched in full so far
    function automatic logic [2:0] full_name_hit();
        for (int k = 0; k < NAME_CNT; k++)
            if (name_live[k] && int'(NAME_LEN[k]) == name_pos)
                return 3'(k);
        return NM_NONE;
    endfunction

    function automatic void close_open_param();
        logic [2:0] hit;
        bit         in_range;
        hit = full_name_hit();
        in_range = win_acc >= WBITS_MIN && win_acc <= WBITS_MAX;
        if (scan_st == SC_PARAM_NAME || scan_st == SC_PARAM_TRAIL) begin
            // bare name
            case (hit)
                NM_CNT:   hdr_flags[FL_CNT] = 1'b1;
                NM_SNT:   hdr_flags[FL_SNT] = 1'b1;
                NM_SBITS: begin
                    hdr_flags[FL_SBITS] = 1'b1;
                    srv_win = '0;
                end
                NM_CBITS: begin
                    hdr_flags[FL_CBITS] = 1'b1;
                    cli_win = '0;
                end
                default: ;
            endcase
        end else if (scan_st == SC_PARAM_VAL || scan_st == SC_PARAM_VAL_END) begin
            // value is kept even out of range, flag only for 8..15
            if (hit == NM_SBITS) begin
                srv_win = win_acc;
                if (in_range)
                    hdr_flags[FL_SBITS] = 1'b1;
            end else if (hit == NM_CBITS) begin
                cli_win = win_acc;
                if (in_range)
                    hdr_flags[FL_CBITS] = 1'b1;
            end
        end
    endfunction

    function automatic void step_name(input logic [7:0] c);
        logic [3:0] keep;
        keep = '0;
        for (int k = 0; k < NAME_CNT; k++)
            if (name_live[k] && name_pos < int'(NAME_LEN[k]) && name_char(k, name_pos) == c)
                keep[k] = 1'b1;
        name_live = keep;
        name_pos++;
        scan_st = (keep != '0) ? SC_PARAM_NAME : SC_PARAM_SKIP;
    endfunction

    function automatic void param_byte(input logic [7:0] c);
        logic [2:0] hit;
        int         v;
        if (c == CH_SEMI || c == CH_COMMA) begin
            close_open_param();
            scan_st = (c == CH_SEMI) ? SC_PARAM_START : SC_DONE;
            return;
        end
        case (scan_st)
            SC_PARAM_START: begin
                if (!is_blank(c)) begin
                    name_live = '1;
                    name_pos = 0;
                    step_name(c);
                end
            end
            SC_PARAM_NAME: begin
                hit = full_name_hit();
                if (hit != NM_NONE && is_blank(c)) begin
                    scan_st = SC_PARAM_TRAIL;
                end else if ((hit == NM_SBITS || hit == NM_CBITS) && c == CH_EQ) begin
                    win_acc = '0;
                    scan_st = SC_PARAM_VAL;
                end else begin
                    step_name(c);
                end
            end
            SC_PARAM_TRAIL: begin
                if (!is_blank(c))
                    scan_st = SC_PARAM_SKIP;
            end
            SC_PARAM_VAL: begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    v = int'(win_acc) * 10 + int'(c - CH_ZERO);
                    win_acc = (v > int'(SAT_MAX)) ? SAT_MAX : 8'(v);
                end else begin
                    scan_st = SC_PARAM_VAL_END;
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        case (scan_st)
            SC_OFFER: begin
                if (c != CH_COMMA && !is_blank(c)) begin
                    if (c == prefix_char(0)) begin
                        name_pos = 1;
                        scan_st = SC_PREFIX;
                    end else begin
                        scan_st = SC_SKIP_OFFER;
                    end
                end
            end
            SC_PREFIX: begin
                if (name_pos < PREFIX_LEN && c == prefix_char(name_pos)) begin
                    name_pos++;
                    if (name_pos == PREFIX_LEN) begin
                        hdr_flags[FL_DEFLATE] = 1'b1;
                        scan_st = SC_AFTER;
                    end
                end else begin
                    scan_st = (c == CH_COMMA) ? SC_OFFER : SC_SKIP_OFFER;
                end
            end
            SC_SKIP_OFFER: begin
                if (c == CH_COMMA)
                    scan_st = SC_OFFER;
            end
            SC_AFTER: scan_st = (c == CH_SEMI) ? SC_PARAM_START : SC_DONE;
            SC_DONE: ;
            default: param_byte(c);
        endcase
    endfunction

    function automatic void finish_string();
        close_open_param();
        scan_st = SC_DONE;
    endfunction

    // one accepted byte; returns 1 with the result on the last byte
    function automatic bit offer_parse_byte(input logic [7:0] c, input logic last,
                                            output t_wseo_out res, output bit consumed);
        res = '0;
        consumed = 1'b0;
        if (scan_st != SC_DONE && hdr_bytes < WSEO_MAX_VALUE_BYTES) begin
            hdr_bytes++;
            consumed = 1'b1;
            if (c == CH_NUL)
                finish_string();
            else
                scan_byte(c);
        end
        if (!last)
            return 1'b0;
        if (scan_st != SC_DONE)
            finish_string();
        res.deflate_offered    = hdr_flags[FL_DEFLATE];
        res.client_no_takeover = hdr_flags[FL_CNT];
        res.server_no_takeover = hdr_flags[FL_SNT];
        res.server_bits_flag   = hdr_flags[FL_SBITS];
        res.client_bits_flag   = hdr_flags[FL_CBITS];
        res.server_bits_value  = srv_win;
        res.client_bits_value  = cli_win;
        // header state clears, stored window values stay
        scan_st   = SC_OFFER;
        name_pos  = 0;
        name_live = '1;
        hdr_bytes = 0;
        hdr_flags = '0;
        win_acc   = '0;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // checking: input beats feed the predictor, result beats are compared
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH %s", msg);
    endtask

    task automatic check_field(input string field, input int got, input int want);
        if (got != want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_checked, field, got, want));
    endtask

    always @(posedge clk) begin : beat_check
        t_wseo_out  want;
        t_wseo_out  got;
        t_hdr_check chk;
        bit         consumed;
        if (rst_n) begin
            // input beat taken at this edge
            if (in_valid && in_ready) begin
                if (offer_parse_byte(in_data.value_byte, in_data.last_byte, want, consumed)) begin
                    if (header_checks.size() != 0) begin
                        chk = header_checks.pop_front();
                        if (chk.typed)
                            want = chk.want;
                    end
                    expected_offers.push_back(want);
                    if (want.deflate_offered)
                        deflate_seen++;
                end
                if (consumed)
                    bytes_parsed++;
            end
            // result beat taken at this edge
            if (out_valid && out_ready) begin
                got = out_data;
                if (expected_offers.size() == 0) begin
                    report_mismatch("result beat with no header pending");
                end else begin
                    want = expected_offers.pop_front();
                    check_field("deflate_offered", got.deflate_offered, want.deflate_offered);
                    check_field("client_no_takeover", got.client_no_takeover,
                                want.client_no_takeover);
                    check_field("server_no_takeover", got.server_no_takeover,
                                want.server_no_takeover);
                    check_field("server_bits_flag", got.server_bits_flag, want.server_bits_flag);
                    check_field("client_bits_flag", got.client_bits_flag, want.client_bits_flag);
                    check_field("server_bits_value", got.server_bits_value,
                                want.server_bits_value);
                    check_field("client_bits_value", got.client_bits_value,
                                want.client_bits_value);
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side: random stall before each beat, none in quiet stretches
    // ------------------------------------------------------------------------
    function automatic int draw_wait();
        return quiet ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    initial begin : result_sink
        int stall;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            stall = draw_wait();
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    // one byte beat; valid stays up across back-to-back beats
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{value_byte: b, last_byte: last};
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_header(input bit typed, input t_wseo_out want);
        header_checks.push_back('{typed, want});
        for (int i = 0; i < hdr_q.size(); i++)
            send_byte(hdr_q[i], i == hdr_q.size() - 1);
        headers_sent++;
    endtask

    // hold off until every pending result beat has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_offers.size() != 0 || header_checks.size() != 0)
            @(posedge clk);
    endtask

    function automatic int name_index(input string tok);
        if (tok == "cnt")
            return int'(NM_CNT);
        if (tok == "snt")
            return int'(NM_SNT);
        if (tok == "sbits")
            return int'(NM_SBITS);
        return int'(NM_CBITS);
    endfunction

    task automatic add_name(input int k);
        for (int p = 0; p < int'(NAME_LEN[k]); p++)
            hdr_q.push_back(name_char(k, p));
    endtask

    // plain text, with a name token expanded to the full parameter name
    task automatic add_text(input string s);
        int    i;
        int    j;
        string tok;
        i = 0;
        while (i < s.len()) begin
            if (s[i] == "{") begin
                j = i + 1;
                while (j < s.len() && s[j] != "}")
                    j++;
                tok = s.substr(i + 1, j - 1);
                add_name(name_index(tok));
                i = j + 1;
            end else begin
                hdr_q.push_back(s[i]);
                i++;
            end
        end
    endtask

    // occasional run of whitespace, any of the six blank characters
    task automatic add_blanks();
        int b;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) begin
                b = $urandom_range(0, 5);
                hdr_q.push_back(b == 5 ? CH_SPACE : CH_TAB + 8'(b));
            end
        end
    endtask

    // one parameter: known name (sometimes cut short or extended), with or
    // without a value, or junk, or nothing at all
    task automatic add_param();
        int k;
        int v;
        int form;
        k = $urandom_range(0, 5);
        if (k < NAME_CNT) begin
            add_name(k);
            case ($urandom_range(0, 7))
                0: void'(hdr_q.pop_back());
                1: add_text("x");
                default: ;
            endcase
            form = $urandom_range(0, 5);
            if (form != 0 && (k >= int'(NM_SBITS) || form == 5)) begin
                add_text("=");
                case ($urandom_range(0, 3))
                    0: v = $urandom_range(8, 15);
                    1: v = $urandom_range(0, 7);
                    2: v = $urandom_range(16, 999);
                    default: v = -1;
                endcase
                if (v >= 0) begin
                    if ($urandom_range(0, 4) == 0)
                        add_text("0");
                    add_text($sformatf("%0d", v));
                end
                if ($urandom_range(0, 5) == 0)
                    add_text("x7");
            end
        end else if (k == 4) begin
            add_text("foo=bar");
        end
    endtask

    task automatic build_random_header();
        int kind;
        hdr_q.delete();
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
            // raw noise, any byte value
            repeat ($urandom_range(1, 24)) hdr_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            if ($urandom_range(0, 2) == 0) begin
                add_text(other_offers[$urandom_range(0, 6)]);
                add_blanks();
                add_text(",");
                add_blanks();
            end
            add_text(kind == 2 ? other_offers[$urandom_range(0, 6)] : "permessage-deflate");
            if ($urandom_range(0, 9) != 0) begin
                add_text(";");
                for (int i = $urandom_range(1, 4); i > 0; i--) begin
                    add_blanks();
                    add_param();
                    add_blanks();
                    if (i > 1)
                        add_text(";");
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                add_text(",");
                add_blanks();
                add_text("permessage-deflate;{cnt}");
            end
            // broken headers: early zero byte or a corrupted byte
            if ($urandom_range(0, 14) == 0)
                hdr_q[$urandom_range(0, hdr_q.size() - 1)] = CH_NUL;
            if ($urandom_range(0, 14) == 0)
                hdr_q[$urandom_range(0, hdr_q.size() - 1)] = 8'($urandom_range(1, 255));
        end
    endtask

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_wseo_out none;
        int        random_headers;
        none = '0;
        random_headers = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_rows[r]) begin
            quiet = ($urandom_range(0, 3) == 0);
            hdr_q.delete();
            repeat (directed_rows[r].fill) hdr_q.push_back(CH_SPACE);
            add_text(directed_rows[r].text);
            if (directed_rows[r].nul_at >= 0)
                hdr_q[directed_rows[r].fill + directed_rows[r].nul_at] = CH_NUL;
            if (hdr_q.size() == 0)
                hdr_q.push_back(CH_NUL);
            send_header(directed_rows[r].typed, directed_rows[r].want);
        end
        quiet = 1'b0;
        drain();

        // random headers, with a full hold-off every few headers
        while (random_headers < RANDOM_HEADERS || beats_sent < TOTAL_BEATS) begin
            quiet = ($urandom_range(0, 4) == 0);
            build_random_header();
            send_header(1'b0, none);
            random_headers++;
            if (random_headers % 4 == 0)
                drain();
        end
        quiet = 1'b0;
        drain();
        repeat (20) @(posedge clk);

        $display("covered %0d headers (%0d random), %0d beats, %0d bytes scanned",
                 headers_sent, random_headers, beats_sent, bytes_parsed);
        $display("%0d deflate offers, %0d result beats checked, %0d mismatches",
                 deflate_seen, results_checked, mismatches);
        if (mismatches == 0 && expected_offers.size() == 0) begin
            $display("tb_websocket_extension_offer_parser passed");
        end else begin
            $display("tb_websocket_extension_offer_parser failed");
        end
        $finish;
    end

endmodule

// File: websocket_extension_offer_parser.f
rtl/core/wseo_pkg.sv
rtl/core/websocket_extension_offer_parser.sv
tb/tb_websocket_extension_offer_parser.sv
